FILE: rtl/ffea_pkg.sv
// ----------------------------------------------------------------------------
// ffea_pkg: shared types and constants for the first-fit extent allocator
// Holds the extent and token structures, opcodes, status codes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ffea_pkg;

	localparam int MAX_EXTENTS = 64;
	localparam int OFF_W       = 32;
	localparam logic [OFF_W-1:0] MEM_SIZE_RST = 32'd16777216;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// What the token is doing as it passes a cell.
	typedef enum logic [2:0] {
		M_SRCH,
		M_DEL,
		M_INS,
		M_DONE,
		M_CLR,
		M_INIT
	} mode_t;

	typedef struct packed {
		logic             vld;
		logic [OFF_W-1:0] start;
		logic [OFF_W-1:0] size;
	} ent_t;

	typedef struct packed {
		logic             vld;
		op_t              op;
		mode_t            mode;
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] len;
		ent_t             carry;
		logic [1:0]       status;
		logic [OFF_W-1:0] grant;
	} tok_t;

	// Clamp a grown size to the largest offset value.
	function automatic logic [OFF_W-1:0] sat_size(input logic [OFF_W+1:0] x);
		logic [OFF_W-1:0] r;
		r = (x[OFF_W+1:OFF_W] != 2'b00) ? {OFF_W{1'b1}} : x[OFF_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ffea_cell.sv
// ----------------------------------------------------------------------------
// ffea_cell: one extent slot of the allocator chain
// Holds one extent and acts on the operation token as it passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module ffea_cell import ffea_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  ent_t rst_ent,
	input  tok_t tin,
	input  ent_t right,
	input  logic full,
	output ent_t ent,
	output tok_t tout
);

	ent_t ent_q, ent_n;
	tok_t tout_q, tout_n;

	logic [OFF_W:0]   own_end;
	logic [OFF_W:0]   blk_end;
	logic [OFF_W+1:0] sum_two;
	logic [OFF_W+1:0] sum_three;
	logic             is_p;
	logic             is_last;

	always_comb begin
		own_end   = {1'b0, ent_q.start} + {1'b0, ent_q.size};
		blk_end   = {1'b0, tin.off} + {1'b0, tin.len};
		sum_two   = {2'b00, ent_q.size} + {2'b00, tin.len};
		sum_three = sum_two + {2'b00, right.size};
		is_p      = !ent_q.vld || (ent_q.start > tin.off);
		is_last   = !right.vld || (right.start > tin.off);
	end

	always_comb begin
		ent_n  = ent_q;
		tout_n = tin;
		if (tin.vld) begin
			unique case (tin.mode)
				M_DONE: begin
				end
				M_CLR: begin
					ent_n.vld = 1'b0;
				end
				M_INIT: begin
					ent_n       = tin.carry;
					tout_n.mode = M_CLR;
				end
				M_DEL: begin
					ent_n = right;
				end
				M_INS: begin
					ent_n        = tin.carry;
					tout_n.carry = ent_q;
					if (!ent_q.vld) begin
						tout_n.mode = M_DONE;
					end
				end
				M_SRCH: begin
					unique case (tin.op)
						OP_ALLOC: begin
							if (!ent_q.vld) begin
								tout_n.status = ST_NOFIT;
								tout_n.mode   = M_DONE;
							end else if (ent_q.size >= tin.len) begin
								tout_n.grant = ent_q.start;
								if (ent_q.size == tin.len) begin
									ent_n       = right;
									tout_n.mode = M_DEL;
								end else begin
									ent_n.start = ent_q.start + tin.len;
									ent_n.size  = ent_q.size - tin.len;
									tout_n.mode = M_DONE;
								end
							end
						end
						OP_FREE: begin
							if (is_p) begin
								if (ent_q.vld && (blk_end == {1'b0, ent_q.start})) begin
									// Block ends where this extent starts: grow it downward.
									ent_n.start = tin.off;
									ent_n.size  = sat_size(sum_two);
									tout_n.mode = M_DONE;
								end else if (full) begin
									tout_n.status = ST_FULL;
									tout_n.mode   = M_DONE;
								end else begin
									ent_n        = '{vld: 1'b1, start: tin.off, size: tin.len};
									tout_n.carry = ent_q;
									tout_n.mode  = ent_q.vld ? M_INS : M_DONE;
								end
							end else if (is_last && (own_end == {1'b0, tin.off})) begin
								if (right.vld && (blk_end == {1'b0, right.start})) begin
									// Bridges this extent and the next: merge all three.
									ent_n.size  = sat_size(sum_three);
									tout_n.mode = M_DEL;
								end else begin
									ent_n.size  = sat_size(sum_two);
									tout_n.mode = M_DONE;
								end
							end
						end
						default: begin
							tout_n.mode = M_DONE;
						end
					endcase
				end
				default: begin
					tout_n.mode = M_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q  <= rst_ent;
			tout_q <= '0;
		end else begin
			ent_q  <= ent_n;
			tout_q <= tout_n;
		end
	end

	assign ent  = ent_q;
	assign tout = tout_q;

endmodule

`default_nettype wire

FILE: rtl/first_fit_extent_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator: first-fit free-extent allocator with coalescing
// A chain of extent cells kept in address order, walked by one token per item.
// ----------------------------------------------------------------------------
// An accepted item is registered as a token, which walks the cell chain one cell
// per cycle; the result is registered as the token leaves the last cell. One
// item is in work at a time; the next is taken once the result has been taken.
// Reset leaves one extent covering the whole region (16 MiB) and no result.
`default_nettype none

module first_fit_extent_allocator import ffea_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration: memory_size register.
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// Request items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] block_offset, [63:32] block_length
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] granted_offset
	output logic [1:0]  m_tuser   // [1:0] status
);

	logic [OFF_W-1:0] mem_size_q;
	logic             busy_q;
	tok_t             tin_q;
	logic             m_vld_q;
	logic [1:0]       m_status_q;
	logic [OFF_W-1:0] m_grant_q;

	ent_t ents [MAX_EXTENTS];
	tok_t toks [MAX_EXTENTS+1];
	logic full;

	logic s_acc;
	logic m_acc;
	tok_t tin_n;
	tok_t tok_end;

	assign s_tready = !busy_q;
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_vld_q && m_tready;
	assign full     = ents[MAX_EXTENTS-1].vld;
	assign toks[0]  = tin_q;
	assign tok_end  = toks[MAX_EXTENTS];

	// Build the token for a new item. Reinitialize carries the whole-region
	// extent into the first cell and then clears the rest of the chain; a
	// zero-length free and the unused opcode finish without touching anything.
	always_comb begin
		tin_n        = '0;
		tin_n.vld    = s_acc;
		tin_n.op     = op_t'(s_tuser);
		tin_n.off    = s_tdata[31:0];
		tin_n.len    = s_tdata[63:32];
		tin_n.status = ST_OK;
		unique case (op_t'(s_tuser))
			OP_ALLOC: tin_n.mode = M_SRCH;
			OP_FREE:  tin_n.mode = (s_tdata[63:32] == '0) ? M_DONE : M_SRCH;
			OP_INIT: begin
				tin_n.mode  = M_INIT;
				tin_n.carry = '{vld: 1'b1, start: '0, size: mem_size_q};
			end
			OP_NOP:   tin_n.mode = M_DONE;
			default:  tin_n.mode = M_DONE;
		endcase
	end

	// The cell chain. Each cell sees its right neighbor so that removals can
	// pull the following extents down as the token passes.
	for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
		ent_t rst_e;
		ent_t right_e;
		assign rst_e = (i == 0) ? ent_t'{vld: 1'b1, start: '0, size: MEM_SIZE_RST} : '0;
		if (i == MAX_EXTENTS - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = ents[i+1];
		end
		ffea_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rst_ent (rst_e),
			.tin     (toks[i]),
			.right   (right_e),
			.full    (full),
			.ent     (ents[i]),
			.tout    (toks[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= MEM_SIZE_RST;
			busy_q     <= 1'b0;
			tin_q      <= '0;
			m_vld_q    <= 1'b0;
			m_status_q <= ST_OK;
			m_grant_q  <= '0;
		end else begin
			if (cfg_we) begin
				mem_size_q <= cfg_wdata;
			end
			tin_q <= tin_n;
			if (s_acc) begin
				busy_q <= 1'b1;
			end else if (m_acc) begin
				busy_q <= 1'b0;
			end
			// A token still searching at the chain end found no place: an
			// allocate had no fit, a free needed a slot in a full table.
			if (tok_end.vld) begin
				m_vld_q <= 1'b1;
				if (tok_end.mode == M_SRCH) begin
					m_status_q <= (tok_end.op == OP_FREE) ? ST_FULL : ST_NOFIT;
				end else begin
					m_status_q <= tok_end.status;
				end
				m_grant_q <= (tok_end.op == OP_ALLOC) ? tok_end.grant : '0;
			end else if (m_acc) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_grant_q;
	assign m_tuser  = m_status_q;

	// The token leaves the chain once it has passed every cell.
	a_token_latency: assert property (@(posedge clk) disable iff (!arst_n)
		tin_q.vld |-> ##MAX_EXTENTS tok_end.vld)
		else $error("token did not leave the chain on time");

	// No token finishes unless an item is in work.
	a_no_stray_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.vld |-> busy_q && !m_vld_q)
		else $error("token finished with no item in work");

	// Valid extents are packed at the front: with the first slot empty and no token near the head, the last slot is empty.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(!ents[0].vld && !toks[1].vld && !tin_q.vld) |-> !ents[MAX_EXTENTS-1].vld)
		else $error("extent table has a gap");

	// Table full is only reported when every slot is in use.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_vld_q && m_status_q == ST_FULL) |-> full)
		else $error("table full reported with a free slot");

endmodule

`default_nettype wire
